>>> rtl/core/tss_pkg.sv
// Shared types and constants for the Taylor sine/cosine pipeline.
package tss_pkg;

    // Internal fixed-point format: Q.24 throughout the term chain.
    localparam int WORK_BITS = 24;
    localparam int XW        = 29;  // signed work angle before reduction
    localparam int UX_W      = 27;  // reduced angle, [0, 2pi)
    localparam int MAG_W     = 31;  // term magnitude
    localparam int V_W       = 34;  // (mag * x) >> 24
    localparam int HALF_W    = 17;  // reciprocal split for partial products
    localparam int DIV_SHIFT = 34;  // reciprocal scale
    localparam int DIV_W     = 6;   // divisor width
    localparam int SUM_W     = 33;  // signed running sum
    localparam int CNT_W     = 4;   // term count

    localparam logic signed [XW-1:0] TWO_PI_W  = 29'sd105414357;
    localparam logic signed [XW-1:0] HALF_PI_W = 29'sd26353589;

    localparam int MAX_TERMS_DEF = 12;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [CNT_W-1:0] TERMS_RESET    = 4'd10;
    localparam logic             REG_TERMS_USED = 1'b0;
    localparam int               PADDR_W        = 3;

    typedef struct packed {
        logic                    vld;
        logic [CNT_W-1:0]        cnt;
        logic [UX_W-1:0]         ux;
        logic signed [SUM_W-1:0] sum;
    } t_lane;

endpackage

>>> rtl/core/tss_mdiv.sv
// One multiply-and-divide step: ((mag * x) >> 24) / D, five stages.
module tss_mdiv #(
    parameter int unsigned D = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  tss_pkg::t_lane               i_lane,
    input  logic [tss_pkg::MAG_W-1:0]    i_mag,
    output tss_pkg::t_lane               o_lane,
    output logic [tss_pkg::MAG_W-1:0]    o_mag
);

    localparam int PROD_W = tss_pkg::MAG_W + tss_pkg::UX_W;
    localparam int PP_W   = tss_pkg::V_W + tss_pkg::HALF_W;
    localparam int Q_W    = tss_pkg::V_W + 2 * tss_pkg::HALF_W;
    localparam int PD_W   = tss_pkg::V_W + tss_pkg::DIV_W;

    localparam logic [63:0] RECIP = (64'd1 << tss_pkg::DIV_SHIFT) / 64'(D);
    localparam logic [tss_pkg::HALF_W-1:0] RECIP_HI =
        RECIP[2*tss_pkg::HALF_W-1:tss_pkg::HALF_W];
    localparam logic [tss_pkg::HALF_W-1:0] RECIP_LO = RECIP[tss_pkg::HALF_W-1:0];
    localparam logic [PD_W-1:0] DIVISOR = PD_W'(D);

    tss_pkg::t_lane r_lane [0:4];

    logic [tss_pkg::V_W-1:0]   r_v1, r_v2, r_v3, r_v4;
    logic [PP_W-1:0]           r_phi, r_plo;
    logic [tss_pkg::V_W-1:0]   r_q3, r_q4;
    logic [PD_W-1:0]           r_pd4;
    logic [tss_pkg::MAG_W-1:0] r_mag5;

    logic [PROD_W-1:0]         w_prod;
    logic [Q_W-1:0]            w_full;
    logic [tss_pkg::V_W-1:0]   n_q;

    assign w_prod = PROD_W'(i_mag) * PROD_W'(i_lane.ux);
    assign w_full = (Q_W'(r_phi) << tss_pkg::HALF_W) + Q_W'(r_plo);
    // estimate is low by at most one
    assign n_q    = (PD_W'(r_v4) >= r_pd4) ? r_q4 + 1'b1 : r_q4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 5; s++) begin
                r_lane[s].vld <= 1'b0;
            end
        end else if (i_en) begin
            r_lane[0] <= i_lane;
            for (int s = 1; s < 5; s++) begin
                r_lane[s] <= r_lane[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v1   <= w_prod[PROD_W-1:tss_pkg::WORK_BITS];
            r_v2   <= r_v1;
            r_phi  <= PP_W'(r_v1) * PP_W'(RECIP_HI);
            r_plo  <= PP_W'(r_v1) * PP_W'(RECIP_LO);
            r_v3   <= r_v2;
            r_q3   <= w_full[Q_W-1:tss_pkg::DIV_SHIFT];
            r_v4   <= r_v3;
            r_q4   <= r_q3;
            r_pd4  <= (PD_W'(r_q3) + PD_W'(1)) * DIVISOR;
            r_mag5 <= tss_pkg::MAG_W'(n_q);
        end
    end

    assign o_lane = r_lane[4];
    assign o_mag  = r_mag5;

endmodule

>>> rtl/core/tss_front.sv
// Front stages: angle to Q.24, cosine offset, reduction into [0, 2pi).
module tss_front #(
    parameter int FRAC_BITS = tss_pkg::FRAC_BITS_DEF,
    parameter int MAX_TERMS = tss_pkg::MAX_TERMS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_vld,
    input  logic                              i_cmd,
    input  logic signed [FRAC_BITS+3:0]       i_angle,
    input  logic [tss_pkg::CNT_W-1:0]         i_terms,
    output tss_pkg::t_lane                    o_lane,
    output logic [tss_pkg::MAG_W-1:0]         o_mag
);

    localparam int AW = FRAC_BITS + 4;
    localparam int XW = tss_pkg::XW;

    logic signed [XW-1:0]          w_work;
    logic signed [XW-1:0]          r_x;
    logic [tss_pkg::CNT_W-1:0]     r_cnt;
    logic [tss_pkg::CNT_W-1:0]     n_cnt;
    logic                          r_vld;
    logic signed [XW-1:0]          n_red;
    tss_pkg::t_lane                r_lane;

    generate
        if (FRAC_BITS <= tss_pkg::WORK_BITS) begin : g_up
            assign w_work = XW'(i_angle) <<< (tss_pkg::WORK_BITS - FRAC_BITS);
        end else begin : g_down
            localparam logic signed [AW:0] RND = (AW+1)'(1) <<< (FRAC_BITS - 25);
            logic signed [AW:0] w_rnd;
            assign w_rnd  = (AW+1)'(i_angle) + RND;
            assign w_work = XW'(w_rnd >>> (FRAC_BITS - tss_pkg::WORK_BITS));
        end
    endgenerate

    always_comb begin
        if ((tss_pkg::CNT_W+1)'(i_terms) > (tss_pkg::CNT_W+1)'(MAX_TERMS)) begin
            n_cnt = tss_pkg::CNT_W'(MAX_TERMS);
        end else begin
            n_cnt = i_terms;
        end
    end

    always_comb begin
        if (r_x < -tss_pkg::TWO_PI_W) begin
            n_red = r_x + (tss_pkg::TWO_PI_W <<< 1);
        end else if (r_x < 0) begin
            n_red = r_x + tss_pkg::TWO_PI_W;
        end else if (r_x >= tss_pkg::TWO_PI_W) begin
            n_red = r_x - tss_pkg::TWO_PI_W;
        end else begin
            n_red = r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_lane.vld <= 1'b0;
        end else if (i_en) begin
            r_vld      <= i_vld;
            r_lane.vld <= r_vld;
            r_x        <= w_work + (i_cmd ? tss_pkg::HALF_PI_W : XW'(0));
            r_cnt      <= n_cnt;
            r_lane.cnt <= r_cnt;
            r_lane.ux  <= tss_pkg::UX_W'(n_red);
            // first term is x itself
            r_lane.sum <= (r_cnt != '0)
                        ? tss_pkg::SUM_W'($unsigned(tss_pkg::UX_W'(n_red)))
                        : tss_pkg::SUM_W'(0);
        end
    end

    assign o_lane = r_lane;
    assign o_mag  = tss_pkg::MAG_W'(r_lane.ux);

endmodule

>>> rtl/core/tss_cell.sv
// One term cell: next term magnitude from the previous one, then accumulate.
module tss_cell #(
    parameter int IDX = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  tss_pkg::t_lane               i_lane,
    input  logic [tss_pkg::MAG_W-1:0]    i_mag,
    output tss_pkg::t_lane               o_lane,
    output logic [tss_pkg::MAG_W-1:0]    o_mag
);

    tss_pkg::t_lane            w_lane_a, w_lane_b;
    logic [tss_pkg::MAG_W-1:0] w_mag_a, w_mag_b;
    tss_pkg::t_lane            r_lane;
    logic [tss_pkg::MAG_W-1:0] r_mag;
    logic signed [tss_pkg::SUM_W-1:0] n_sum;
    logic signed [tss_pkg::SUM_W-1:0] w_term;

    tss_mdiv #(.D(2 * IDX)) u_div_even (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_lane  (i_lane),
        .i_mag   (i_mag),
        .o_lane  (w_lane_a),
        .o_mag   (w_mag_a)
    );

    tss_mdiv #(.D(2 * IDX + 1)) u_div_odd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_lane  (w_lane_a),
        .i_mag   (w_mag_a),
        .o_lane  (w_lane_b),
        .o_mag   (w_mag_b)
    );

    assign w_term = tss_pkg::SUM_W'(w_mag_b);

    always_comb begin
        n_sum = w_lane_b.sum;
        if (tss_pkg::CNT_W'(IDX) < w_lane_b.cnt) begin
            if ((IDX % 2) == 1) begin
                n_sum = w_lane_b.sum - w_term;
            end else begin
                n_sum = w_lane_b.sum + w_term;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane.vld <= 1'b0;
        end else if (i_en) begin
            r_lane.vld <= w_lane_b.vld;
            r_lane.cnt <= w_lane_b.cnt;
            r_lane.ux  <= w_lane_b.ux;
            r_lane.sum <= n_sum;
            r_mag      <= w_mag_b;
        end
    end

    assign o_lane = r_lane;
    assign o_mag  = r_mag;

endmodule

>>> rtl/core/taylor_sine_cosine.sv
// Top level: register port, front stages, chain of term cells, rounding and output skid.
//
//  channel   dir  handshake            payload
//  request   in   i_valid / o_ready    i_cmd, i_angle
//  result    out  o_valid / i_ready    o_value
//  config    in   psel/penable/pready  paddr, pwdata, pwrite, prdata
//
// One request per cycle while o_ready is high, fully pipelined through the front stages,
// the cell chain and the back end, where each term cell is two five-stage
// multiply/divide steps plus an accumulate stage.
// Reset is synchronous and clears valid bits and terms_used (to 10).
// A stalled output parks one result in a skid register; o_ready then drops and
// the whole pipeline holds until the skid register drains.
module taylor_sine_cosine #(
    parameter int FRAC_BITS = tss_pkg::FRAC_BITS_DEF,
    parameter int MAX_TERMS = tss_pkg::MAX_TERMS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tss_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_cmd,
    input  logic signed [FRAC_BITS+3:0]       i_angle,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [FRAC_BITS+1:0]       o_value
);

    localparam int VW    = FRAC_BITS + 2;
    localparam int SUM_W = tss_pkg::SUM_W;
    localparam int RW    = (FRAC_BITS > tss_pkg::WORK_BITS)
                         ? SUM_W + FRAC_BITS - tss_pkg::WORK_BITS : SUM_W;
    localparam logic [RW-1:0] LIM = RW'(1) << (FRAC_BITS + 1);

    // configuration
    logic [tss_pkg::CNT_W-1:0] r_terms;
    logic                      w_reg_idx;

    assign w_reg_idx = paddr[2];
    assign pready    = 1'b1;
    assign prdata    = (w_reg_idx == tss_pkg::REG_TERMS_USED) ? 32'(r_terms) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_terms <= tss_pkg::TERMS_RESET;
        end else if (psel && penable && pwrite && pready
                     && w_reg_idx == tss_pkg::REG_TERMS_USED) begin
            r_terms <= pwdata[tss_pkg::CNT_W-1:0];
        end
    end

    // pipeline enable
    logic r_skid_vld;
    logic w_en;

    assign w_en    = !r_skid_vld;
    assign o_ready = w_en;

    tss_pkg::t_lane            w_lane [0:MAX_TERMS-1];
    logic [tss_pkg::MAG_W-1:0] w_mag  [0:MAX_TERMS-1];

    tss_front #(
        .FRAC_BITS (FRAC_BITS),
        .MAX_TERMS (MAX_TERMS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_valid),
        .i_cmd   (i_cmd),
        .i_angle (i_angle),
        .i_terms (r_terms),
        .o_lane  (w_lane[0]),
        .o_mag   (w_mag[0])
    );

    generate
        for (genvar k = 1; k < MAX_TERMS; k++) begin : g_cell
            tss_cell #(.IDX(k)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_lane  (w_lane[k-1]),
                .i_mag   (w_mag[k-1]),
                .o_lane  (w_lane[k]),
                .o_mag   (w_mag[k])
            );
        end
    endgenerate

    // back end: magnitude, rounding, saturation
    tss_pkg::t_lane w_tail;
    logic           r_b1_vld, r_b2_vld, r_p_vld;
    logic           r_b1_neg, r_b2_neg;
    logic [SUM_W-1:0] r_b1_mag;
    logic [RW-1:0]    r_b2_rm;
    logic [RW-1:0]    n_rm;
    logic [RW-1:0]    n_sat;
    logic [VW-1:0]    n_val;
    logic [VW-1:0]    r_p_val;

    assign w_tail = w_lane[MAX_TERMS-1];

    generate
        if (FRAC_BITS < tss_pkg::WORK_BITS) begin : g_rnd
            localparam logic [SUM_W-1:0] HALF =
                SUM_W'(1) << (tss_pkg::WORK_BITS - FRAC_BITS - 1);
            logic [SUM_W-1:0] w_add;
            assign w_add = r_b1_mag + HALF;
            assign n_rm  = RW'(w_add >> (tss_pkg::WORK_BITS - FRAC_BITS));
        end else begin : g_shl
            assign n_rm = RW'(r_b1_mag) << (FRAC_BITS - tss_pkg::WORK_BITS);
        end
    endgenerate

    always_comb begin
        if (r_b2_neg) begin
            n_sat = (r_b2_rm > LIM) ? LIM : r_b2_rm;
            n_val = VW'(~n_sat + RW'(1));
        end else begin
            n_sat = (r_b2_rm > LIM - RW'(1)) ? LIM - RW'(1) : r_b2_rm;
            n_val = VW'(n_sat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld <= 1'b0;
            r_b2_vld <= 1'b0;
            r_p_vld  <= 1'b0;
        end else if (w_en) begin
            r_b1_vld <= w_tail.vld;
            r_b2_vld <= r_b1_vld;
            r_p_vld  <= r_b2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b1_neg <= w_tail.sum[SUM_W-1];
            r_b1_mag <= w_tail.sum[SUM_W-1] ? SUM_W'(-w_tail.sum) : SUM_W'(w_tail.sum);
            r_b2_neg <= r_b1_neg;
            r_b2_rm  <= n_rm;
            r_p_val  <= n_val;
        end
    end

    // output register and skid
    logic          r_out_vld;
    logic [VW-1:0] r_out_val;
    logic [VW-1:0] r_skid_val;
    logic          w_take;

    assign w_take = r_out_vld && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || w_take) begin
            r_out_vld <= r_p_vld;
        end else if (r_p_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_take) begin
                r_out_val <= r_skid_val;
            end
        end else if (!r_out_vld || w_take) begin
            r_out_val <= r_p_val;
        end else begin
            r_skid_val <= r_p_val;
        end
    end

    assign o_valid = r_out_vld;
    assign o_value = r_out_val;

endmodule

>>> tb/taylor_sine_cosine_checker.sv
// Checker for taylor_sine_cosine: predicts each sine/cosine value, compares results and checks terms_used readback.
`timescale 1ns / 1ps
module taylor_sine_cosine_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [tss_pkg::PADDR_W-1:0]   i_paddr,
    input  logic [31:0]                   i_pwdata,
    input  logic [31:0]                   i_prdata,
    input  logic                          i_pready,
    input  logic                          i_req_valid,
    input  logic                          i_req_ready,
    input  logic                          i_cmd,
    input  logic signed [19:0]            i_angle,
    input  logic                          i_res_valid,
    input  logic                          i_res_ready,
    input  logic signed [17:0]            i_value,
    output int                            o_fail_count,
    output int                            o_pending
);

    localparam int     ANGLE_W       = 20;
    localparam int     VALUE_W       = 18;
    localparam int     TERM_LIMIT    = 12;
    localparam int     Q24_SHIFT     = 8;
    localparam int     WORK_SHIFT    = 24;
    localparam logic   CMD_COSINE    = 1'b1;
    localparam longint TWO_PI_Q24    = 64'sd105414357;
    localparam longint HALF_PI_Q24   = 64'sd26353589;
    localparam longint VALUE_POS_MAX = 64'sd131071;
    localparam longint VALUE_NEG_MAG = 64'sd131072;

    logic [tss_pkg::CNT_W-1:0]   terms_cfg;
    logic signed [VALUE_W-1:0]   pending_values[$];
    logic signed [VALUE_W-1:0]   want;
    int                          fail_count = 0;

    assign o_fail_count = fail_count;

    // Odd Taylor series of sin(x), x reduced to [0, 2pi) in Q.24.
    function automatic logic signed [VALUE_W-1:0] taylor_value(
        input logic                      cmd,
        input logic signed [ANGLE_W-1:0] angle,
        input logic [tss_pkg::CNT_W-1:0] terms
    );
        longint    x;
        longint    sum;
        bit [63:0] ux;
        bit [63:0] mag;
        bit [63:0] rounded;
        int        n;
        logic      neg;
        x = longint'(angle) <<< Q24_SHIFT;
        if (cmd == CMD_COSINE) begin
            x += HALF_PI_Q24;
        end
        x = x % TWO_PI_Q24;
        if (x < 0) begin
            x += TWO_PI_Q24;
        end
        ux  = x;
        n   = (terms > TERM_LIMIT) ? TERM_LIMIT : int'(terms);
        mag = ux;
        sum = 0;
        for (int i = 0; i < n; i++) begin
            if (i % 2 == 1) begin
                sum -= longint'(mag);
            end else begin
                sum += longint'(mag);
            end
            mag = ((mag * ux) >> WORK_SHIFT) / 64'(2 * i + 2);
            mag = ((mag * ux) >> WORK_SHIFT) / 64'(2 * i + 3);
        end
        neg     = sum < 0;
        rounded = neg ? 64'(-sum) : 64'(sum);
        rounded = (rounded + (64'd1 << (Q24_SHIFT - 1))) >> Q24_SHIFT;
        if (neg) begin
            if (rounded > 64'(VALUE_NEG_MAG)) begin
                rounded = 64'(VALUE_NEG_MAG);
            end
            rounded = -rounded;
        end else if (rounded > 64'(VALUE_POS_MAX)) begin
            rounded = 64'(VALUE_POS_MAX);
        end
        return rounded[VALUE_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            terms_cfg = tss_pkg::TERMS_RESET;
            pending_values.delete();
        end else begin
            if (i_psel && i_penable && i_pready
                    && i_paddr[tss_pkg::PADDR_W-1:2] == tss_pkg::REG_TERMS_USED) begin
                if (i_pwrite) begin
                    terms_cfg = i_pwdata[tss_pkg::CNT_W-1:0];
                end else if (i_prdata !== 32'(terms_cfg)) begin
                    $error("terms_used readback: expected %0d, actual %0d",
                           terms_cfg, i_prdata);
                    fail_count++;
                end
            end
            if (i_res_valid && i_res_ready) begin
                if (pending_values.size() == 0) begin
                    $error("value: unexpected result %0d", i_value);
                    fail_count++;
                end else begin
                    want = pending_values.pop_front();
                    if (i_value !== want) begin
                        $error("value mismatch: expected %0d, actual %0d", want, i_value);
                        fail_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                pending_values.push_back(taylor_value(i_cmd, i_angle, terms_cfg));
            end
        end
        o_pending = pending_values.size();
    end

endmodule

>>> tb/taylor_sine_cosine_tb.sv
// Testbench top for taylor_sine_cosine: clock, reset, request/config stimulus and verdict.
`timescale 1ns / 1ps
module taylor_sine_cosine_tb;

    localparam int CLK_PERIOD   = 10;
    localparam int ANGLE_W      = 20;
    localparam int VALUE_W      = 18;
    localparam int QUARTER_TURN = 102944;
    localparam int DRAIN_CYCLES = 140;
    localparam int HOLD_CYCLES  = 800;
    localparam int PHASE_ITEMS  = 165;
    localparam int HOLD_ITEMS   = 250;
    localparam int HOLD_PHASE   = 4;
    localparam int NUM_PHASES   = 9;
    localparam int TIMEOUT_NS   = 3_000_000;

    localparam logic [tss_pkg::PADDR_W-1:0] TERMS_ADDR    = {tss_pkg::REG_TERMS_USED, 2'b00};
    localparam logic [tss_pkg::PADDR_W-1:0] UNMAPPED_ADDR = {~tss_pkg::REG_TERMS_USED, 2'b00};

    localparam int TERMS_PLAN[NUM_PHASES] = '{0, 1, 2, 5, 12, 15, 13, 7, 3};
    localparam int DIRECTED_ANGLES[12] = '{0, 1, -1, 524287, -524288, 102944, 205887,
                                           308831, 411775, 411774, -411775, -102944};

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [tss_pkg::PADDR_W-1:0]   paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          req_valid;
    logic                          req_ready;
    logic                          req_cmd;
    logic signed [ANGLE_W-1:0]     req_angle;
    logic                          res_valid;
    logic                          res_ready;
    logic signed [VALUE_W-1:0]     res_value;
    int                            fail_count;
    int                            pending;
    bit                            no_idle = 1'b0;
    bit                            hold_request = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    taylor_sine_cosine DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_valid (req_valid),
        .o_ready (req_ready),
        .i_cmd   (req_cmd),
        .i_angle (req_angle),
        .o_valid (res_valid),
        .i_ready (res_ready),
        .o_value (res_value)
    );

    taylor_sine_cosine_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_cmd        (req_cmd),
        .i_angle      (req_angle),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_value      (res_value),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic logic signed [ANGLE_W-1:0] random_angle();
        int base;
        case ($urandom_range(0, 3))
            0, 1: base = int'($urandom());
            2: base = (int'($urandom_range(0, 10)) - 5) * QUARTER_TURN
                      + int'($urandom_range(0, 16)) - 8;
            default: begin
                base = int'($urandom_range(0, 127)) - 64;
                if ($urandom_range(0, 1) == 1) begin
                    base += 524288;
                end
            end
        endcase
        return ANGLE_W'(base);
    endfunction

    // Entered and left at a falling edge.
    task automatic send_request(input logic cmd, input logic signed [ANGLE_W-1:0] angle);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_cmd   <= cmd;
        req_angle <= angle;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apb_access(input logic write, input logic [tss_pkg::PADDR_W-1:0] addr,
                              input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_terms(input int terms);
        apb_access(1'b1, TERMS_ADDR, {28'($urandom()), 4'(terms)});
        apb_access(1'b0, TERMS_ADDR, 32'd0);
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            no_idle = (i >= 40 && i < 80);
            send_request(1'($urandom()), random_angle());
        end
        no_idle   = 1'b0;
        req_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        int stall;
        res_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 4);
                if (stall > 0) begin
                    res_ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
            res_ready <= 1'b1;
            @(posedge clk);
            while (!res_valid && !hold_request) @(posedge clk);
            @(negedge clk);
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("taylor_sine_cosine_tb: FAIL");
        $finish;
    end

    initial begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        req_valid = 1'b0;
        req_cmd   = 1'b0;
        req_angle = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        apb_access(1'b0, TERMS_ADDR, 32'd0);
        for (int k = 0; k < 24; k++) begin
            send_request(k[0], ANGLE_W'(DIRECTED_ANGLES[k / 2]));
        end
        run_random(150);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            set_terms(TERMS_PLAN[p]);
            if (p == HOLD_PHASE) begin
                // unmapped write must leave terms_used alone
                apb_access(1'b1, UNMAPPED_ADDR, $urandom());
                apb_access(1'b0, TERMS_ADDR, 32'd0);
                hold_request = 1'b1;
                run_random(HOLD_ITEMS);
            end else begin
                run_random(PHASE_ITEMS);
            end
        end

        wait_idle();
        if (fail_count == 0) begin
            $display("taylor_sine_cosine_tb: PASS");
        end else begin
            $display("taylor_sine_cosine_tb: FAIL");
        end
        $finish;
    end

endmodule
